@@ rtl/ale_pkg.sv @@
// Shared types and codes for the array list engine.
// Depends on nothing; used by ale_cell and array_list_engine_unit.
`default_nettype none

package ale_pkg;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_SORTED = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BADPOS   = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Shift command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic del;
	} shift_cmd_t;

	localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

@@ rtl/ale_cell.sv @@
// One storage cell of the list chain: holds one element and its compare flags.
// Depends on ale_pkg.
`default_nettype none

module ale_cell #(
	parameter int IW  = 6,
	parameter int IDX = 0
) (
	input  wire                            clk,
	input  wire                            capture,
	input  wire signed [ale_pkg::DATA_W-1:0] probe,
	input  wire ale_pkg::shift_cmd_t       cmd,
	input  wire        [IW-1:0]            at_idx,
	input  wire signed [ale_pkg::DATA_W-1:0] ins_val,
	input  wire signed [ale_pkg::DATA_W-1:0] left_val,
	input  wire signed [ale_pkg::DATA_W-1:0] right_val,
	output logic signed [ale_pkg::DATA_W-1:0] elem,
	output logic                           eq,
	output logic                           lt
);

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic signed [ale_pkg::DATA_W-1:0] elem_q;
	logic eq_q;
	logic lt_q;

	always_ff @(posedge clk) begin
		if (capture) begin
			eq_q <= (elem_q == probe);
			lt_q <= (elem_q < probe);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (MY_IDX == at_idx) begin
				elem_q <= ins_val;
			end else if (MY_IDX > at_idx) begin
				elem_q <= left_val;
			end
		end else if (cmd.del) begin
			if (MY_IDX >= at_idx) begin
				elem_q <= right_val;
			end
		end
	end

	assign elem = elem_q;
	assign eq   = eq_q;
	assign lt   = lt_q;

endmodule

`default_nettype wire

@@ rtl/ale_find_first.sv @@
// Lowest-index finder over the registered per-cell match flags.
// Depends on nothing outside this file.
`default_nettype none

module ale_find_first #(
	parameter int N  = 64,
	parameter int IW = 6
) (
	input  wire [N-1:0]  flags,
	output logic         found,
	output logic [IW-1:0] idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = N - 1; i >= 0; i--) begin
			if (flags[i]) begin
				found = 1'b1;
				idx   = IW'(i);
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/array_list_engine_unit.sv @@
// Top level of the array list engine: a chain of element cells, a lowest-index
// finder and the command sequencing. Depends on ale_pkg, ale_cell, ale_find_first.
`default_nettype none

// Usage.
// A command beat (opcode, value, position) is taken at a rising edge where
// start is high and busy is low. busy then stays high for one cycle.
// At the accept edge every cell compares its element with value and keeps
// an equal flag and a less-than flag. In the following cycle the finder
// picks the lowest valid cell whose flag is set (equal for locate, not less
// for sorted insert), the status is decided, and at the next edge every cell
// loads its new element from itself, its left or right neighbor or the
// inserted value, all in parallel.
// The result beat (status, index, count) is on its ports for exactly one
// cycle with done high, registered at the edge that ends the busy cycle. The
// receiver cannot stall, so nothing waits: a new command may be taken in the
// same cycle the result is shown, but not while busy is high.
// The result follows the compare registered in the cells and the finder plus
// shift that follows it.
// Reset clears the element count, busy and done; element contents are not
// cleared, and only entries below the count are ever used.
module array_list_engine_unit #(
	parameter int CAPACITY = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  wire        [1:0]  opcode,
	input  wire signed [31:0] value,
	input  wire        [6:0]  position,
	output logic              done,
	output logic       [1:0]  status,
	output logic       [5:0]  index,
	output logic       [6:0]  count
);

	localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;

	// Command and result registers; the command fields are loaded when a beat is accepted.
	logic                           busy_q;
	logic                           done_q;
	logic [CW-1:0]                  count_q;
	ale_pkg::op_t                   op_q;
	logic signed [ale_pkg::DATA_W-1:0] val_q;
	logic [6:0]                     pos_q;
	ale_pkg::status_t               status_q;
	logic [5:0]                     index_q;

	logic accept;
	assign accept = start && !busy_q;

	// Cell chain.
	logic signed [ale_pkg::DATA_W-1:0] elem [CAPACITY];
	logic [CAPACITY-1:0] eq_v;
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] valid_v;
	ale_pkg::shift_cmd_t cmd;
	logic [IW-1:0]       at_idx;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic signed [ale_pkg::DATA_W-1:0] left_w;
			logic signed [ale_pkg::DATA_W-1:0] right_w;
			if (g == 0) begin : g_first
				assign left_w = elem[g];
			end else begin : g_mid_l
				assign left_w = elem[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign right_w = elem[g];
			end else begin : g_mid_r
				assign right_w = elem[g+1];
			end
			ale_cell #(
				.IW (IW),
				.IDX(g)
			) u_cell (
				.clk      (clk),
				.capture  (accept),
				.probe    (value),
				.cmd      (cmd),
				.at_idx   (at_idx),
				.ins_val  (val_q),
				.left_val (left_w),
				.right_val(right_w),
				.elem     (elem[g]),
				.eq       (eq_v[g]),
				.lt       (lt_v[g])
			);
			assign valid_v[g] = (CW'(g) < count_q);
		end
	endgenerate

	// The finder looks for a match on locate and for the first entry that is
	// not less than the value on sorted insert.
	logic [CAPACITY-1:0] find_v;
	logic                ff_found;
	logic [IW-1:0]       ff_idx;

	assign find_v = (op_q == ale_pkg::OP_LOCATE) ? (eq_v & valid_v) : (~lt_v & valid_v);

	ale_find_first #(
		.N (CAPACITY),
		.IW(IW)
	) u_find (
		.flags(find_v),
		.found(ff_found),
		.idx  (ff_idx)
	);

	// Decision for the command in flight.
	ale_pkg::status_t st_d;
	logic [IW-1:0]    res_idx;
	logic [CW-1:0]    count_d;
	logic             do_ins;
	logic             do_del;
	logic [CMPW-1:0]  pos_ext;
	logic [CMPW-1:0]  cnt_ext;
	logic             full;

	assign pos_ext = CMPW'(pos_q);
	assign cnt_ext = CMPW'(count_q);
	assign full    = (count_q == CW'(CAPACITY));

	always_comb begin
		st_d    = ale_pkg::ST_OK;
		res_idx = '0;
		count_d = count_q;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		at_idx  = IW'(pos_q);
		case (op_q)
			ale_pkg::OP_INSERT: begin
				if (pos_ext > cnt_ext) begin
					st_d = ale_pkg::ST_BADPOS;
				end else if (full) begin
					st_d = ale_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					res_idx = at_idx;
					count_d = count_q + CW'(1);
				end
			end
			ale_pkg::OP_DELETE: begin
				if (pos_ext >= cnt_ext) begin
					st_d = ale_pkg::ST_BADPOS;
				end else begin
					do_del  = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			ale_pkg::OP_LOCATE: begin
				if (ff_found) begin
					res_idx = ff_idx;
				end else begin
					st_d = ale_pkg::ST_NOTFOUND;
				end
			end
			ale_pkg::OP_SORTED: begin
				at_idx = ff_found ? ff_idx : IW'(count_q);
				if (full) begin
					st_d = ale_pkg::ST_FULL;
				end else begin
					do_ins  = 1'b1;
					res_idx = at_idx;
					count_d = count_q + CW'(1);
				end
			end
			default: begin
				st_d = ale_pkg::ST_OK;
			end
		endcase
	end

	assign cmd.ins = busy_q && do_ins;
	assign cmd.del = busy_q && do_del;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			busy_q <= accept;
			done_q <= busy_q;
			if (busy_q) begin
				count_q <= count_d;
			end
		end
	end

	// Payload registers.
	logic [31:0] idx_wide;
	assign idx_wide = 32'(res_idx);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= ale_pkg::op_t'(opcode);
			val_q <= value;
			pos_q <= position;
		end
		if (busy_q) begin
			status_q <= st_d;
			index_q  <= idx_wide[5:0];
		end
	end

	logic [31:0] count_wide;
	assign count_wide = 32'(count_q);

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;
	assign index  = index_q;
	assign count  = count_wide[6:0];

	// A result follows exactly one busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("result strobe without a command in flight");

	// A command is in flight for one cycle only.
	a_busy_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !busy_q)
		else $error("busy held longer than one cycle");

	// The count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// A failed command leaves the count unchanged.
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && status_q != ale_pkg::ST_OK) |-> (count_q == $past(count_q)))
		else $error("failed command changed the count");

endmodule

`default_nettype wire

@@ tb/sv/array_list_engine_unit_test.sv @@
// Self-checking testbench for the array list engine: drives command beats,
// predicts each result beat with a scoreboard class and compares field by field.
// Depends on ale_pkg and array_list_engine_unit.
`timescale 1ns / 1ps

module array_list_engine_unit_test;

	localparam int CAPACITY       = 64;
	localparam int RANDOM_ITEMS   = 1500;
	// The slowest legal run is about 1525 command beats, each preceded by at most
	// the longest gap that pick_gap draws. The limit leaves ample margin.
	localparam int unsigned CYCLE_LIMIT = 400000;

	// One expected result beat, at the widths of the result ports.
	typedef struct packed {
		ale_pkg::status_t status;
		logic [5:0]       index;
		logic [6:0]       count;
	} list_result_t;

	// The scoreboard keeps its own copy of the list contents and the element
	// count. Every accepted command beat is applied to that copy at the accept
	// edge, and the result it must produce is queued. Each result beat the
	// block shows is then compared with the oldest queued result.
	class list_scoreboard;
		logic signed [31:0] elements [CAPACITY];
		int unsigned        element_count;
		list_result_t       pending_results [$];
		int unsigned        mismatches;

		function new();
			element_count = 0;
			mismatches    = 0;
		endfunction

		task report(string msg);
			$display("%0t ns: mismatch: %s", $time, msg);
			mismatches++;
		endtask

		function logic signed [31:0] element_at(int unsigned slot);
			return elements[slot];
		endfunction

		// Opens a hole at slot by moving every later entry up, then fills it.
		function void shift_in(int unsigned slot, logic signed [31:0] val);
			int unsigned i;
			for (i = element_count; i > slot; i--)
				elements[i] = elements[i - 1];
			elements[slot] = val;
			element_count++;
		endfunction

		function void note_command(ale_pkg::op_t op, logic signed [31:0] val,
				logic [6:0] pos);
			list_result_t want;
			int unsigned  slot;
			int unsigned  i;
			bit           found;
			want.status = ale_pkg::ST_OK;
			want.index  = '0;
			slot        = 32'(pos);
			found       = 1'b0;
			case (op)
				ale_pkg::OP_INSERT: begin
					// A position past the count is refused before fullness is looked at.
					if (slot > element_count)
						want.status = ale_pkg::ST_BADPOS;
					else if (element_count >= CAPACITY)
						want.status = ale_pkg::ST_FULL;
					else begin
						shift_in(slot, val);
						want.index = slot[5:0];
					end
				end
				ale_pkg::OP_DELETE: begin
					if (slot >= element_count)
						want.status = ale_pkg::ST_BADPOS;
					else begin
						for (i = slot; i + 1 < element_count; i++)
							elements[i] = elements[i + 1];
						element_count--;
					end
				end
				ale_pkg::OP_LOCATE: begin
					want.status = ale_pkg::ST_NOTFOUND;
					for (i = 0; i < element_count && !found; i++) begin
						if (elements[i] == val) begin
							found       = 1'b1;
							want.status = ale_pkg::ST_OK;
							want.index  = i[5:0];
						end
					end
				end
				default: begin
					// Sorted insert goes before the first entry that is not less,
					// scanning from the bottom even when the list is out of order.
					if (element_count >= CAPACITY)
						want.status = ale_pkg::ST_FULL;
					else begin
						i = 0;
						while (i < element_count && elements[i] < val)
							i++;
						shift_in(i, val);
						want.index = i[5:0];
					end
				end
			endcase
			want.count = element_count[6:0];
			pending_results.push_back(want);
		endfunction

		task check_result(logic [1:0] st, logic [5:0] idx, logic [6:0] cnt);
			list_result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("result beat status=%0d index=%0d count=%0d with no command waiting",
					st, idx, cnt));
			end else begin
				want = pending_results.pop_front();
				if (st !== want.status)
					report($sformatf("status %0d, expected %0d", st, want.status));
				if (idx !== want.index)
					report($sformatf("index %0d, expected %0d", idx, want.index));
				if (cnt !== want.count)
					report($sformatf("count %0d, expected %0d", cnt, want.count));
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic        [1:0]  opcode;
	logic signed [31:0] value;
	logic        [6:0]  position;
	wire                busy;
	wire                done;
	wire         [1:0]  status;
	wire         [5:0]  index;
	wire         [6:0]  count;

	list_scoreboard sb;
	int unsigned    cycle_count;
	bit             no_idle;
	bit             filling;

	array_list_engine_unit #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.opcode  (opcode),
		.value   (value),
		.position(position),
		.done    (done),
		.status  (status),
		.index   (index),
		.count   (count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Runaway guard. A hung handshake or a lost result beat ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver cannot hold results off, so every cycle with done high is a
	// result beat. Outputs are sampled at the rising edge, before the block's
	// own updates of that edge take effect.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1)
			sb.check_result(status, index, count);
	end

	// Idle cycles before a command beat: most beats follow at once or after a
	// short pause, a few after a long one. Stretches with no idling are set by
	// no_idle, which the stimulus loop redraws now and then.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 65)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Values lean toward a small pool, the extremes and entries already in the
	// list, so that locate hits, duplicates and signed ordering all occur.
	function automatic logic signed [31:0] pick_value();
		int unsigned        roll;
		logic signed [31:0] v;
		roll = $urandom_range(0, 99);
		if (roll < 20 && sb.element_count > 0)
			return sb.element_at($urandom_range(0, sb.element_count - 1));
		if (roll < 45) begin
			v = $urandom_range(0, 6);
			v = v - 3;
			return v;
		end
		if (roll < 55) begin
			case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7FFF_FFFF;
				2: v = 32'hFFFF_FFFF;
				default: v = 32'h0000_0000;
			endcase
			return v;
		end
		v = $urandom;
		return v;
	endfunction

	// Positions cluster around the current count, where the boundary checks
	// live, and otherwise range from zero up to the capacity.
	function automatic logic [6:0] pick_position();
		int unsigned cnt;
		int unsigned roll;
		cnt  = sb.element_count;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 7'($urandom_range(0, cnt));
		if (roll < 65)
			return 7'(cnt);
		if (roll < 80)
			return 7'((cnt < CAPACITY) ? cnt + 1 : CAPACITY);
		if (roll < 90 && cnt > 0)
			return 7'(cnt - 1);
		return 7'($urandom_range(0, CAPACITY));
	endfunction

	// Drives one command beat. Inputs change only at the falling edge; during
	// idle cycles the payload ports carry noise with start low. start is held
	// high with a steady payload until a rising edge sees busy low, and the
	// beat is handed to the scoreboard at that edge.
	task automatic send_command(ale_pkg::op_t op, logic signed [31:0] val,
			logic [6:0] pos);
		int unsigned gap;
		bit          taken;
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start    = 1'b0;
			opcode   = 2'($urandom);
			value    = $urandom;
			position = 7'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start    = 1'b1;
		opcode   = op;
		value    = val;
		position = pos;
		taken    = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		sb.note_command(op, val, pos);
	endtask

	initial begin
		int           n;
		int unsigned  roll;
		ale_pkg::op_t op;
		logic [6:0]   pos;

		sb          = new();
		cycle_count = 0;
		no_idle     = 1'b0;
		filling     = 1'b1;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = '0;
		value       = '0;
		position    = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part. On the empty list: a locate miss, a delete out of range
		// and inserts past the count, including the top position.
		send_command(ale_pkg::OP_LOCATE, 32'sd0, 7'd0);
		send_command(ale_pkg::OP_DELETE, 32'sd0, 7'd0);
		send_command(ale_pkg::OP_INSERT, 32'sd7, 7'd1);
		send_command(ale_pkg::OP_INSERT, 32'sd7, 7'd64);
		// Build a list from the signed extremes. The second sorted zero lands
		// before the equal entry already there.
		send_command(ale_pkg::OP_INSERT, 32'hFFFF_FFFF, 7'd0);
		send_command(ale_pkg::OP_SORTED, 32'h7FFF_FFFF, 7'd0);
		send_command(ale_pkg::OP_SORTED, 32'h8000_0000, 7'd127);
		send_command(ale_pkg::OP_SORTED, 32'h0000_0000, 7'd0);
		send_command(ale_pkg::OP_SORTED, 32'h0000_0000, 7'd64);
		// Insert exactly at the count, and in the middle, with alternating bits.
		send_command(ale_pkg::OP_INSERT, 32'h5555_5555, 7'd5);
		send_command(ale_pkg::OP_INSERT, 32'hAAAA_AAAA, 7'd3);
		// Locate the lowest duplicate, both extremes and a miss.
		send_command(ale_pkg::OP_LOCATE, 32'h0000_0000, 7'd64);
		send_command(ale_pkg::OP_LOCATE, 32'h7FFF_FFFF, 7'd0);
		send_command(ale_pkg::OP_LOCATE, 32'h8000_0000, 7'd0);
		send_command(ale_pkg::OP_LOCATE, 32'sd12345, 7'd0);
		// Delete at the count is refused; delete the last and the first entry.
		send_command(ale_pkg::OP_DELETE, 32'sd0, 7'd7);
		send_command(ale_pkg::OP_DELETE, 32'sd0, 7'd6);
		send_command(ale_pkg::OP_DELETE, 32'h7FFF_FFFF, 7'd0);
		send_command(ale_pkg::OP_DELETE, 32'sd0, 7'd64);
		send_command(ale_pkg::OP_LOCATE, 32'h5555_5555, 7'd0);
		send_command(ale_pkg::OP_LOCATE, 32'hAAAA_AAAA, 7'd0);

		// Random part. The mix swings between filling and draining, so the list
		// passes through empty and full again and again; at full, insert and
		// sorted insert must both report full, while an insert past the count
		// still reports a bad position. One beat in ten ignores the mix.
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			if (filling && sb.element_count == CAPACITY && $urandom_range(0, 5) == 0)
				filling = 1'b0;
			else if (!filling && sb.element_count == 0 && $urandom_range(0, 2) == 0)
				filling = 1'b1;
			roll = $urandom_range(0, 99);
			pos  = pick_position();
			if (roll < 10) begin
				op  = ale_pkg::op_t'($urandom_range(0, 3));
				pos = 7'($urandom_range(0, CAPACITY));
			end else if (filling) begin
				if (roll < 45)
					op = ale_pkg::OP_SORTED;
				else if (roll < 70)
					op = ale_pkg::OP_INSERT;
				else if (roll < 85)
					op = ale_pkg::OP_LOCATE;
				else
					op = ale_pkg::OP_DELETE;
			end else begin
				if (roll < 60)
					op = ale_pkg::OP_DELETE;
				else if (roll < 80)
					op = ale_pkg::OP_LOCATE;
				else if (roll < 90)
					op = ale_pkg::OP_INSERT;
				else
					op = ale_pkg::OP_SORTED;
			end
			send_command(op, pick_value(), pos);
		end

		@(negedge clk);
		start = 1'b0;

		// Every command gives exactly one result beat, registered at the end of its
		// busy cycle. Wait for the last one, then a few more cycles so that a stray
		// extra beat is still caught.
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
